// ----- design/assert_macros.svh -----
// ----------------------------------------------------------------------------
// assert_macros.svh
// Clocked assertion helpers used by nat_port_session_table.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// check a property on every rising clk edge outside reset
`define NST_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// check a property on every rising clk edge, reset included
`define NST_ASSERT_ALWAYS(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ----- design/nst_pkg.sv -----
// ----------------------------------------------------------------------------
// nst_pkg
// Types and constants of the NAT port session table.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
package nst_pkg;

	localparam int TABLE_ENTRIES = 256;
	localparam int IDX_W = $clog2(TABLE_ENTRIES);
	localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TABLE_ENTRIES - 1);
	localparam int WIN = 8;
	localparam int CFG_IDX_W = 2;

	localparam logic [3:0] CMD_ALLOC      = 4'd0;
	localparam logic [3:0] CMD_INSERT     = 4'd1;
	localparam logic [3:0] CMD_REM_PORT   = 4'd2;
	localparam logic [3:0] CMD_REM_MAC    = 4'd3;
	localparam logic [3:0] CMD_FIND_PORT  = 4'd4;
	localparam logic [3:0] CMD_FIND_IP    = 4'd5;
	localparam logic [3:0] CMD_FIND_IPP   = 4'd6;
	localparam logic [3:0] CMD_FIND_MAC   = 4'd7;
	localparam logic [3:0] CMD_CLEAR      = 4'd8;

	localparam logic [1:0] ST_OK     = 2'd0;
	localparam logic [1:0] ST_MISS   = 2'd1;
	localparam logic [1:0] ST_NOPORT = 2'd2;
	localparam logic [1:0] ST_FULL   = 2'd3;

	localparam logic [CFG_IDX_W-1:0] REG_PORT_MIN = CFG_IDX_W'(0);
	localparam logic [CFG_IDX_W-1:0] REG_PORT_MAX = CFG_IDX_W'(1);

	typedef struct packed {
		logic        valid;
		logic [15:0] ext_port;
		logic [15:0] int_port;
		logic [47:0] mac;
		logic [31:0] ip;
	} entry_t;

endpackage
`default_nettype wire

// ----- design/nst_cell.sv -----
// ----------------------------------------------------------------------------
// nst_cell
// One session slot of the rotating table; passes its entry on every cycle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module nst_cell
	import nst_pkg::*;
(
	input  wire logic   clk,
	input  wire logic   arst_n,
	input  wire logic   clear,
	input  wire entry_t d,
	output entry_t      q
);

	logic valid_q;
	entry_t data_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else begin
			valid_q <= clear ? 1'b0 : d.valid;
		end
	end

	always_ff @(posedge clk) begin
		data_q <= d;
	end

	always_comb begin
		q = data_q;
		q.valid = valid_q;
	end

endmodule
`default_nettype wire

// ----- design/nat_port_session_table.sv -----
// ----------------------------------------------------------------------------
// nat_port_session_table
// Source-NAT session table: allocate, insert, remove, find and clear.
// ----------------------------------------------------------------------------
// Usage:
//   s_* carries one command request, m_* one result per request; cfg_* writes
//   port_min (index 0) and port_max (index 1). The user must write them only
//   while the block is idle; the block itself does not enforce it.
//   Sessions sit in a ring of TABLE_ENTRIES cells that rotates every cycle,
//   and every key compare is done at the ring head.
//   Find scans the ring once; insert and remove scan it and then wait for the
//   target slot to come round; allocate also rescans it once per window of 8
//   candidate ports before its write. Clear and unknown commands skip the scan.
//   One request is worked on at a time; s_tready rises again once the result
//   is in the output register, so the next request may start while the
//   result waits for m_tready. A stalled receiver holds the result; the next
//   result then waits, and no further request is taken until it is loaded.
//   Reset empties the table and sets port_min 1024, port_max 65535; the
//   table is usable right after reset.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"
module nat_port_session_table
	import nst_pkg::*;
(
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 s_tvalid,
	output logic                      s_tready,
	// command, external_port, internal_port, host_mac, public_ip, pad
	input  wire logic [119:0]         s_tdata,
	output logic                      m_tvalid,
	input  wire logic                 m_tready,
	// status, found_port, found_internal_port, found_mac, found_ip, pad
	output logic [119:0]              m_tdata,
	input  wire logic                 cfg_valid,
	output logic                      cfg_ready,
	input  wire logic [CFG_IDX_W-1:0] cfg_index,
	input  wire logic [15:0]          cfg_data
);

	typedef enum logic [2:0] {
		S_IDLE, S_SCAN, S_DECIDE, S_PORT, S_PDECIDE, S_WRITE, S_RESP
	} state_t;

	state_t state_q;
	logic [3:0] cmd_q;
	logic [15:0] ep_q, ipt_q;
	logic [47:0] mac_q;
	logic [31:0] ip_q;
	logic [IDX_W-1:0] cnt_q, pos_q, free_idx_q, best_idx_q, wr_idx_q;
	logic free_found_q, best_found_q;
	entry_t best_q, wr_entry_q, rsp_q;
	logic [1:0] rsp_status_q;
	logic [16:0] cand_q;
	logic [WIN-1:0] held_q, held_n;
	logic [15:0] port_min_q, port_max_q;
	logic out_valid_q;
	logic [119:0] out_data_q;

	entry_t ring_q [TABLE_ENTRIES];
	entry_t head, tail;
	logic clear_all, accept, hit, last;
	logic pick_ok;
	logic [16:0] pick, cand_j, cand_end;

	assign accept = s_tvalid && s_tready;
	assign s_tready = (state_q == S_IDLE);
	assign cfg_ready = 1'b1;
	assign m_tvalid = out_valid_q;
	assign m_tdata = out_data_q;
	assign head = ring_q[TABLE_ENTRIES-1];
	assign last = (cnt_q == LAST_IDX);
	assign clear_all = accept && (s_tdata[3:0] == CMD_CLEAR);
	assign cand_end = cand_q + 17'(WIN);

	always_comb begin
		tail = head;
		if (state_q == S_WRITE && pos_q == wr_idx_q) begin
			tail = wr_entry_q;
		end
	end

	genvar k;
	generate
		for (k = 0; k < TABLE_ENTRIES; k++) begin : g_cell
			if (k == 0) begin : g_first
				nst_cell u_cell (.clk(clk), .arst_n(arst_n), .clear(clear_all),
					.d(tail), .q(ring_q[k]));
			end else begin : g_next
				nst_cell u_cell (.clk(clk), .arst_n(arst_n), .clear(clear_all),
					.d(ring_q[k-1]), .q(ring_q[k]));
			end
		end
	endgenerate

	always_comb begin
		case (cmd_q)
			CMD_INSERT, CMD_REM_PORT, CMD_FIND_PORT: hit = (head.ext_port == ep_q);
			CMD_FIND_IP:  hit = (head.ip == ip_q);
			CMD_FIND_IPP: hit = (head.ip == ip_q) && (head.int_port == ipt_q);
			CMD_REM_MAC, CMD_FIND_MAC: hit = (head.mac == mac_q) && (head.int_port == ipt_q);
			default: hit = 1'b0;
		endcase
	end

	always_comb begin
		held_n = held_q;
		pick_ok = 1'b0;
		pick = cand_q;
		for (int j = WIN - 1; j >= 0; j--) begin
			cand_j = cand_q + 17'(j);
			if (head.valid && head.ext_port == cand_j[15:0]) begin
				held_n[j] = 1'b1;
			end
			if (!held_q[j] && cand_j <= {1'b0, port_max_q}) begin
				pick_ok = 1'b1;
				pick = cand_j;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			port_min_q <= 16'd1024;
			port_max_q <= 16'd65535;
		end else if (cfg_valid && cfg_ready) begin
			if (cfg_index == REG_PORT_MIN) begin
				port_min_q <= cfg_data;
			end else if (cfg_index == REG_PORT_MAX) begin
				port_max_q <= cfg_data;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q <= '0;
		end else begin
			pos_q <= (pos_q == LAST_IDX) ? '0 : pos_q + 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			cmd_q <= '0;
			ep_q <= '0;
			ipt_q <= '0;
			mac_q <= '0;
			ip_q <= '0;
			cnt_q <= '0;
			free_idx_q <= '0;
			best_idx_q <= '0;
			wr_idx_q <= '0;
			free_found_q <= 1'b0;
			best_found_q <= 1'b0;
			best_q <= '0;
			wr_entry_q <= '0;
			rsp_q <= '0;
			rsp_status_q <= ST_OK;
			cand_q <= '0;
			held_q <= '0;
			out_valid_q <= 1'b0;
			out_data_q <= '0;
		end else begin
			if (state_q == S_RESP && (!out_valid_q || m_tready)) begin
				out_valid_q <= 1'b1;
				out_data_q <= {6'd0, rsp_q.ip, rsp_q.mac, rsp_q.int_port,
					rsp_q.ext_port, rsp_status_q};
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						cmd_q <= s_tdata[3:0];
						ep_q <= s_tdata[19:4];
						ipt_q <= s_tdata[35:20];
						mac_q <= s_tdata[83:36];
						ip_q <= s_tdata[115:84];
						cnt_q <= '0;
						free_found_q <= 1'b0;
						best_found_q <= 1'b0;
						rsp_q <= '0;
						if (s_tdata[3:0] == CMD_CLEAR) begin
							rsp_status_q <= ST_OK;
							state_q <= S_RESP;
						end else if (s_tdata[3:0] > CMD_CLEAR) begin
							rsp_status_q <= ST_MISS;
							state_q <= S_RESP;
						end else begin
							state_q <= S_SCAN;
						end
					end
				end
				S_SCAN: begin
					if (!head.valid && !free_found_q) begin
						free_found_q <= 1'b1;
						free_idx_q <= pos_q;
					end
					if (head.valid && hit &&
					    (!best_found_q || head.ext_port < best_q.ext_port)) begin
						best_found_q <= 1'b1;
						best_q <= head;
						best_idx_q <= pos_q;
					end
					cnt_q <= cnt_q + 1'b1;
					if (last) begin
						state_q <= S_DECIDE;
					end
				end
				S_DECIDE: begin
					cnt_q <= '0;
					held_q <= '0;
					priority case (cmd_q)
						CMD_ALLOC: begin
							if (!free_found_q) begin
								rsp_status_q <= ST_FULL;
								state_q <= S_RESP;
							end else if (port_min_q > port_max_q) begin
								rsp_status_q <= ST_NOPORT;
								state_q <= S_RESP;
							end else begin
								cand_q <= {1'b0, port_min_q};
								state_q <= S_PORT;
							end
						end
						CMD_INSERT: begin
							if (best_found_q || free_found_q) begin
								wr_idx_q <= best_found_q ? best_idx_q : free_idx_q;
								wr_entry_q <= '{valid: 1'b1, ext_port: ep_q,
									int_port: ipt_q, mac: mac_q, ip: ip_q};
								rsp_status_q <= ST_OK;
								rsp_q <= '{valid: 1'b1, ext_port: ep_q, int_port: ipt_q,
									mac: mac_q, ip: ip_q};
								state_q <= S_WRITE;
							end else begin
								rsp_status_q <= ST_FULL;
								state_q <= S_RESP;
							end
						end
						CMD_REM_PORT, CMD_REM_MAC: begin
							if (best_found_q) begin
								wr_idx_q <= best_idx_q;
								wr_entry_q <= '{valid: 1'b0, ext_port: best_q.ext_port,
									int_port: best_q.int_port, mac: best_q.mac,
									ip: best_q.ip};
								rsp_status_q <= ST_OK;
								rsp_q <= best_q;
								state_q <= S_WRITE;
							end else begin
								rsp_status_q <= ST_MISS;
								state_q <= S_RESP;
							end
						end
						default: begin
							rsp_status_q <= best_found_q ? ST_OK : ST_MISS;
							if (best_found_q) begin
								rsp_q <= best_q;
							end
							state_q <= S_RESP;
						end
					endcase
				end
				S_PORT: begin
					held_q <= held_n;
					cnt_q <= cnt_q + 1'b1;
					if (last) begin
						state_q <= S_PDECIDE;
					end
				end
				S_PDECIDE: begin
					cnt_q <= '0;
					held_q <= '0;
					if (pick_ok) begin
						wr_idx_q <= free_idx_q;
						wr_entry_q <= '{valid: 1'b1, ext_port: pick[15:0], int_port: ipt_q,
							mac: mac_q, ip: ip_q};
						rsp_q <= '{valid: 1'b1, ext_port: pick[15:0], int_port: ipt_q,
							mac: mac_q, ip: ip_q};
						rsp_status_q <= ST_OK;
						state_q <= S_WRITE;
					end else if (cand_end > {1'b0, port_max_q}) begin
						rsp_status_q <= ST_NOPORT;
						state_q <= S_RESP;
					end else begin
						cand_q <= cand_end;
						state_q <= S_PORT;
					end
				end
				S_WRITE: begin
					if (pos_q == wr_idx_q) begin
						state_q <= S_RESP;
					end
				end
				S_RESP: begin
					if (!out_valid_q || m_tready) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	`NST_ASSERT(a_one_request, s_tvalid && s_tready |=> !s_tready, "request taken while busy")
	`NST_ASSERT(a_load_from_resp, $rose(m_tvalid) |-> $past(state_q == S_RESP), "result not from response state")
	`NST_ASSERT(a_write_leaves, state_q == S_WRITE && pos_q == wr_idx_q |=> state_q == S_RESP, "write slot missed")

endmodule
`default_nettype wire

// ----- verif/tb.sv -----
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for nat_port_session_table: directed command sequences,
// then phases of random session traffic under several port ranges. A local
// table model predicts every answer, and each answer is checked in order.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
module tb;
	import nst_pkg::*;

	localparam int KEY_PORT = 0;
	localparam int KEY_IP = 1;
	localparam int KEY_IP_PORT = 2;
	localparam int KEY_MAC_PORT = 3;

	typedef struct packed {
		logic [1:0]  status;
		logic [15:0] port;
		logic [15:0] iport;
		logic [47:0] mac;
		logic [31:0] ip;
	} answer_t;

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 s_tvalid = 1'b0;
	logic                 s_tready;
	logic [119:0]         s_tdata = '0;
	logic                 m_tvalid;
	logic                 m_tready = 1'b0;
	logic [119:0]         m_tdata;
	logic                 cfg_valid = 1'b0;
	logic                 cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [15:0]          cfg_data = '0;

	bit          tbl_valid [TABLE_ENTRIES];
	logic [15:0] tbl_port  [TABLE_ENTRIES];
	logic [15:0] tbl_iport [TABLE_ENTRIES];
	logic [47:0] tbl_mac   [TABLE_ENTRIES];
	logic [31:0] tbl_ip    [TABLE_ENTRIES];
	logic [15:0] cur_min = 16'd1024;
	logic [15:0] cur_max = 16'd65535;

	answer_t     answer_q[$];
	int          errors = 0;
	bit          quiet = 1'b0;
	logic [47:0] mac_pool [8];
	logic [31:0] ip_pool  [8];

	nat_port_session_table DUT (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
		.cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	always #10 clk = ~clk;

	function automatic int lowest_hit(int kind, logic [15:0] ep, logic [15:0] ipt,
			logic [47:0] mac, logic [31:0] ip);
		int best;
		bit hit;
		best = -1;
		for (int i = 0; i < TABLE_ENTRIES; i++) begin
			if (tbl_valid[i]) begin
				case (kind)
					KEY_PORT: hit = tbl_port[i] == ep;
					KEY_IP: hit = tbl_ip[i] == ip;
					KEY_IP_PORT: hit = tbl_ip[i] == ip && tbl_iport[i] == ipt;
					default: hit = tbl_mac[i] == mac && tbl_iport[i] == ipt;
				endcase
				if (hit && (best < 0 || tbl_port[i] < tbl_port[best]))
					best = i;
			end
		end
		return best;
	endfunction

	function automatic int free_slot();
		for (int i = 0; i < TABLE_ENTRIES; i++)
			if (!tbl_valid[i])
				return i;
		return -1;
	endfunction

	function automatic bit port_held(int p);
		for (int i = 0; i < TABLE_ENTRIES; i++)
			if (tbl_valid[i] && tbl_port[i] == p)
				return 1'b1;
		return 1'b0;
	endfunction

	function automatic answer_t entry_answer(int i);
		answer_t a;
		a = '{ST_OK, tbl_port[i], tbl_iport[i], tbl_mac[i], tbl_ip[i]};
		return a;
	endfunction

	function automatic void store_entry(int i, logic [15:0] ep, logic [15:0] ipt,
			logic [47:0] mac, logic [31:0] ip);
		tbl_valid[i] = 1'b1;
		tbl_port[i] = ep;
		tbl_iport[i] = ipt;
		tbl_mac[i] = mac;
		tbl_ip[i] = ip;
	endfunction

	function automatic answer_t session_answer(logic [3:0] c, logic [15:0] ep,
			logic [15:0] ipt, logic [47:0] mac, logic [31:0] ip);
		answer_t a;
		int slot;
		a = '{ST_MISS, 16'd0, 16'd0, 48'd0, 32'd0};
		case (c)
			CMD_ALLOC: begin
				slot = free_slot();
				if (slot < 0) begin
					a.status = ST_FULL;
				end else begin
					a.status = ST_NOPORT;
					for (int p = cur_min; p <= int'(cur_max); p++) begin
						if (!port_held(p)) begin
							store_entry(slot, p[15:0], ipt, mac, ip);
							a = entry_answer(slot);
							break;
						end
					end
				end
			end
			CMD_INSERT: begin
				slot = lowest_hit(KEY_PORT, ep, ipt, mac, ip);
				if (slot < 0)
					slot = free_slot();
				if (slot < 0) begin
					a.status = ST_FULL;
				end else begin
					store_entry(slot, ep, ipt, mac, ip);
					a = entry_answer(slot);
				end
			end
			CMD_REM_PORT, CMD_REM_MAC: begin
				slot = lowest_hit(c == CMD_REM_PORT ? KEY_PORT : KEY_MAC_PORT,
					ep, ipt, mac, ip);
				if (slot >= 0) begin
					a = entry_answer(slot);
					tbl_valid[slot] = 1'b0;
				end
			end
			CMD_FIND_PORT, CMD_FIND_IP, CMD_FIND_IPP, CMD_FIND_MAC: begin
				slot = lowest_hit(int'(c - CMD_FIND_PORT), ep, ipt, mac, ip);
				if (slot >= 0)
					a = entry_answer(slot);
			end
			CMD_CLEAR: begin
				for (int i = 0; i < TABLE_ENTRIES; i++)
					tbl_valid[i] = 1'b0;
				a.status = ST_OK;
			end
			default: ;
		endcase
		return a;
	endfunction

	task automatic send_cmd(logic [3:0] c, logic [15:0] ep, logic [15:0] ipt,
			logic [47:0] mac, logic [31:0] ip);
		int gap;
		gap = quiet ? 0 : $urandom_range(0, 18);
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tdata <= {4'd0, ip, mac, ipt, ep, c};
		s_tvalid <= 1'b1;
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		answer_q.insert(answer_q.size(), session_answer(c, ep, ipt, mac, ip));
	endtask

	task automatic drain();
		s_tvalid <= 1'b0;
		while (answer_q.size() != 0) @(posedge clk);
		repeat (10) @(posedge clk);
	endtask

	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [15:0] val);
		drain();
		cfg_index <= idx;
		cfg_data <= val;
		cfg_valid <= 1'b1;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		cfg_valid <= 1'b0;
		if (idx == REG_PORT_MIN)
			cur_min = val;
		else
			cur_max = val;
	endtask

	task automatic set_range(logic [15:0] lo, logic [15:0] hi);
		write_reg(REG_PORT_MIN, lo);
		write_reg(REG_PORT_MAX, hi);
	endtask

	always @(posedge clk) begin
		answer_t want, got;
		if (m_tvalid && m_tready) begin
			got = '{m_tdata[1:0], m_tdata[17:2], m_tdata[33:18], m_tdata[81:34],
				m_tdata[113:82]};
			if (answer_q.size() == 0) begin
				$error("unexpected result %h", got);
				errors++;
			end else begin
				want = answer_q.pop_front();
				if (got.status != want.status) begin
					$error("status exp %0d got %0d", want.status, got.status);
					errors++;
				end
				if (got.port != want.port) begin
					$error("found_port exp %0d got %0d", want.port, got.port);
					errors++;
				end
				if (got.iport != want.iport) begin
					$error("found_internal_port exp %0d got %0d", want.iport, got.iport);
					errors++;
				end
				if (got.mac != want.mac) begin
					$error("found_mac exp %h got %h", want.mac, got.mac);
					errors++;
				end
				if (got.ip != want.ip) begin
					$error("found_ip exp %h got %h", want.ip, got.ip);
					errors++;
				end
			end
		end
	end

	initial begin
		int n;
		@(posedge arst_n);
		forever begin
			n = quiet ? 0 : $urandom_range(0, 18);
			if (n > 0) begin
				m_tready <= 1'b0;
				repeat (n) @(posedge clk);
			end
			m_tready <= 1'b1;
			@(posedge clk);
			while (!m_tvalid) @(posedge clk);
		end
	end

	task automatic test_commands();
		send_cmd(CMD_ALLOC, 16'd0, 16'd80, 48'h0011_2233_4455, 32'hC0A8_0001);
		send_cmd(CMD_FIND_PORT, 16'd1024, 16'd0, 48'd0, 32'd0);
		send_cmd(CMD_FIND_IP, 16'd0, 16'd0, 48'd0, 32'hC0A8_0001);
		send_cmd(CMD_FIND_IPP, 16'd0, 16'd80, 48'd0, 32'hC0A8_0001);
		send_cmd(CMD_FIND_MAC, 16'd0, 16'd80, 48'h0011_2233_4455, 32'd0);
		send_cmd(CMD_INSERT, 16'hFFFF, 16'hFFFF, 48'hFFFF_FFFF_FFFF, 32'hFFFF_FFFF);
		send_cmd(CMD_INSERT, 16'd0, 16'd0, 48'd0, 32'd0);
		send_cmd(CMD_INSERT, 16'hFFFF, 16'd7, 48'h1, 32'h2);
		send_cmd(CMD_FIND_IP, 16'd0, 16'd0, 48'd0, 32'hFFFF_FFFF);
		send_cmd(CMD_REM_MAC, 16'd0, 16'd80, 48'h0011_2233_4455, 32'd0);
		send_cmd(CMD_REM_PORT, 16'd1024, 16'd0, 48'd0, 32'd0);
		send_cmd(CMD_REM_PORT, 16'hFFFF, 16'd0, 48'd0, 32'd0);
		send_cmd(CMD_FIND_MAC, 16'd0, 16'd80, 48'h0011_2233_4455, 32'd0);
		send_cmd(4'd9, 16'd0, 16'd0, 48'd0, 32'd0);
		send_cmd(4'd15, 16'hFFFF, 16'hFFFF, 48'hFFFF_FFFF_FFFF, 32'hFFFF_FFFF);
		send_cmd(CMD_CLEAR, 16'd0, 16'd0, 48'd0, 32'd0);
		send_cmd(CMD_FIND_PORT, 16'd0, 16'd0, 48'd0, 32'd0);
	endtask

	task automatic test_port_range();
		set_range(16'd0, 16'd65535);
		send_cmd(CMD_ALLOC, 16'd0, 16'd1, 48'hA, 32'hB);
		set_range(16'd65535, 16'd65535);
		send_cmd(CMD_ALLOC, 16'd0, 16'd2, 48'hA, 32'hB);
		send_cmd(CMD_ALLOC, 16'd0, 16'd3, 48'hA, 32'hB);
		set_range(16'd10, 16'd5);
		send_cmd(CMD_ALLOC, 16'd0, 16'd4, 48'hA, 32'hB);
		set_range(16'd100, 16'd102);
		repeat (4) send_cmd(CMD_ALLOC, 16'd0, 16'd5, 48'hA, 32'hB);
		send_cmd(CMD_CLEAR, 16'd0, 16'd0, 48'd0, 32'd0);
	endtask

	task automatic test_table_full();
		set_range(16'd1, 16'd65535);
		for (int i = 0; i < TABLE_ENTRIES; i++)
			send_cmd(CMD_INSERT, 16'(2000 + i), 16'($urandom),
				{16'($urandom), 32'($urandom)}, 32'($urandom));
		send_cmd(CMD_ALLOC, 16'd0, 16'd9, 48'hC, 32'hD);
		send_cmd(CMD_INSERT, 16'd5, 16'd9, 48'hC, 32'hD);
		send_cmd(CMD_INSERT, 16'd2010, 16'd9, 48'hC, 32'hD);
		send_cmd(CMD_REM_PORT, 16'd2100, 16'd0, 48'd0, 32'd0);
		send_cmd(CMD_ALLOC, 16'd0, 16'd9, 48'hC, 32'hD);
		send_cmd(CMD_CLEAR, 16'd0, 16'd0, 48'd0, 32'd0);
	endtask

	task automatic test_random_traffic(int count);
		logic [3:0]  c;
		logic [15:0] ep, ipt;
		logic [47:0] mac;
		logic [31:0] ip;
		int          r;
		for (int k = 0; k < count; k++) begin
			if (k % 48 == 0)
				quiet = $urandom_range(0, 3) == 0;
			r = $urandom_range(0, 99);
			if (r < 22) c = CMD_ALLOC;
			else if (r < 40) c = CMD_INSERT;
			else if (r < 50) c = CMD_REM_PORT;
			else if (r < 58) c = CMD_REM_MAC;
			else if (r < 70) c = CMD_FIND_PORT;
			else if (r < 79) c = CMD_FIND_IP;
			else if (r < 88) c = CMD_FIND_IPP;
			else if (r < 96) c = CMD_FIND_MAC;
			else if (r < 98) c = CMD_CLEAR;
			else c = 4'($urandom_range(9, 15));
			if ($urandom_range(0, 9) == 0) begin
				ep = 16'($urandom);
				ipt = 16'($urandom);
				mac = {16'($urandom), 32'($urandom)};
				ip = 32'($urandom);
			end else begin
				ep = 16'(cur_min + $urandom_range(0, 40));
				ipt = 16'($urandom_range(0, 3));
				mac = mac_pool[$urandom_range(0, 7)];
				ip = ip_pool[$urandom_range(0, 7)];
			end
			send_cmd(c, ep, ipt, mac, ip);
		end
		quiet = 1'b0;
	endtask

	initial begin
		for (int i = 0; i < 8; i++) begin
			mac_pool[i] = {16'($urandom), 32'($urandom)};
			ip_pool[i] = 32'($urandom);
		end
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_commands();
		test_port_range();
		test_table_full();
		set_range(16'd1024, 16'd65535);
		test_random_traffic(140);
		set_range(16'd0, 16'd30);
		test_random_traffic(130);
		set_range(16'd65500, 16'd65535);
		test_random_traffic(130);
		set_range(16'($urandom_range(1, 60000)), 16'd65535);
		test_random_traffic(130);
		set_range(16'd1, 16'd65535);
		test_random_traffic(130);
		drain();
		repeat (20) @(posedge clk);
		if (errors == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

	initial begin
		#1_000_000_000;
		$display("FAIL");
		$finish;
	end

endmodule
